/* rtl/vertex_project_top_assert.svh */
// Assertion macros for the vertex projection block.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef VERTEX_PROJECT_TOP_ASSERT_SVH
`define VERTEX_PROJECT_TOP_ASSERT_SVH

// same-cycle implication
`define VP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vertex_project_top: check failed");

// next-cycle implication
`define VP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vertex_project_top: check failed");

`endif

/* rtl/vp_pkg.sv */
// Package for the vertex projection block: fixed-point format, widths, codes.
// No dependencies.
`default_nettype none
package vp_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PROJECT = 1'b1;
  localparam int IN_DW = 136;
  localparam int OUT_DW = 96;
  localparam int QBITS = 31;
  localparam int DW = 34;
  localparam int RW = DW + QBITS + 1;
  localparam int PIPE_DEPTH = 6 + QBITS;
  localparam int CW = $clog2(PIPE_DEPTH + 1);

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [DW-1:0]    dd;
    logic [QBITS-1:0] q;
    logic             neg;
    logic             sat;
  } div_t;
endpackage
`default_nettype wire

/* rtl/vertex_project_top.sv */
// Vertex projection: modelview and projection transform, divide, screen map.
// Depends on vp_pkg.
// Project path: products, eye, products, clip, divider steps, output register.
// One project item per cycle unless output stalls; a load waits until none is in flight.
// Reset: clears the matrix store to zero and empties the pipeline.
`default_nettype none
module vertex_project_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // entry_index, entry_value, point_x, point_y, point_z, zero pad
  input  wire logic [vp_pkg::IN_DW-1:0]  s_axis_tdata_i,
  // func
  input  wire logic                      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // screen_x, screen_y, depth
  output logic [vp_pkg::OUT_DW-1:0]      m_axis_tdata_o,
  // valid_res
  output logic                           m_axis_tuser_o
);
  localparam int F = vp_pkg::FRAC_BITS;
  localparam int RW = vp_pkg::RW;
  localparam int DW = vp_pkg::DW;
  localparam int QB = vp_pkg::QBITS;
  localparam int CW = vp_pkg::CW;

  function automatic logic signed [31:0] dot_round(input logic signed [63:0] p0,
      input logic signed [63:0] p1, input logic signed [63:0] p2,
      input logic signed [63:0] p3);
    logic signed [66:0] s;
    logic signed [66:0] t;
    s = 67'(p0) + 67'(p1) + 67'(p2) + 67'(p3) + (67'sd1 <<< (F - 1));
    t = s >>> F;
    if (t[66:31] == '0 || t[66:31] == '1) begin
      return t[31:0];
    end
    return t[66] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic vp_pkg::div_t div_step(input vp_pkg::div_t s, input int b);
    vp_pkg::div_t o;
    logic [RW-1:0] trial;
    o = s;
    trial = RW'(s.dd) << b;
    if (s.rem >= trial) begin
      o.rem = s.rem - trial;
      o.q[b] = 1'b1;
    end
    return o;
  endfunction

  logic signed [31:0] mat_q [32];
  logic [CW-1:0] cnt_q, cnt_d;
  logic adv, acc_proj, acc_load, out_hs;
  logic v1_q, v2_q, v3_q, v4_q, m_valid_q;
  logic vb_q [0:QB];
  logic signed [63:0] prod1_q [4][4];
  logic signed [31:0] eye_q [4];
  logic signed [63:0] prod3_q [3][4];
  logic signed [31:0] ez3_q;
  logic signed [31:0] clip_q [3];
  logic signed [32:0] den4_q;
  logic zero4_q;
  vp_pkg::div_t dv_q [0:QB][3];
  logic zf_q [0:QB];
  logic [vp_pkg::OUT_DW-1:0] out_data_q;
  logic out_user_q;
  logic signed [31:0] pt [3];

  assign pt[0] = s_axis_tdata_i[68:37];
  assign pt[1] = s_axis_tdata_i[100:69];
  assign pt[2] = s_axis_tdata_i[132:101];

  assign adv = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (s_axis_tuser_i == vp_pkg::FUNC_PROJECT) ? adv : (cnt_q == '0);
  assign acc_proj = s_axis_tvalid_i && s_axis_tready_o
                    && s_axis_tuser_i == vp_pkg::FUNC_PROJECT;
  assign acc_load = s_axis_tvalid_i && s_axis_tready_o
                    && s_axis_tuser_i == vp_pkg::FUNC_LOAD;
  assign out_hs = m_valid_q && m_axis_tready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (acc_proj && !out_hs) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!acc_proj && out_hs) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        mat_q[i] <= '0;
      end
    end else if (acc_load) begin
      mat_q[s_axis_tdata_i[4:0]] <= s_axis_tdata_i[36:5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      m_valid_q <= 1'b0;
      for (int j = 0; j <= QB; j++) begin
        vb_q[j] <= 1'b0;
      end
    end else begin
      cnt_q <= cnt_d;
      if (adv) begin
        v1_q <= acc_proj;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        vb_q[0] <= v4_q;
        for (int j = 1; j <= QB; j++) begin
          vb_q[j] <= vb_q[j-1];
        end
        m_valid_q <= vb_q[QB];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod1_q[r][k] <= mat_q[5'(4 * k + r)] * pt[k];
        end
        prod1_q[r][3] <= $signed({{(32 - F){mat_q[5'(12 + r)][31]}},
                                  mat_q[5'(12 + r)], {F{1'b0}}});
        eye_q[r] <= dot_round(prod1_q[r][0], prod1_q[r][1], prod1_q[r][2], prod1_q[r][3]);
      end
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 4; k++) begin
          prod3_q[r][k] <= mat_q[5'(16 + 4 * k + r)] * eye_q[k];
        end
        clip_q[r] <= dot_round(prod3_q[r][0], prod3_q[r][1], prod3_q[r][2], prod3_q[r][3]);
      end
      ez3_q <= eye_q[2];
      den4_q <= 33'sd0 - 33'(ez3_q);
      zero4_q <= (ez3_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] an;
    logic [32:0] ad;
    logic [RW-1:0] nn;
    logic [RW-1:0] dd2;
    if (adv) begin
      ad = den4_q[32] ? 33'(-den4_q) : 33'(den4_q);
      for (int l = 0; l < 3; l++) begin
        an = clip_q[l][31] ? 33'(-33'(clip_q[l])) : 33'(clip_q[l]);
        nn = (RW'(an) << (F + 1)) + RW'(ad);
        dd2 = RW'(ad) << 1;
        dv_q[0][l].rem <= nn;
        dv_q[0][l].dd <= DW'(dd2);
        dv_q[0][l].q <= '0;
        dv_q[0][l].neg <= clip_q[l][31] ^ den4_q[32];
        dv_q[0][l].sat <= nn >= (dd2 << QB);
        for (int j = 1; j <= QB; j++) begin
          dv_q[j][l] <= div_step(dv_q[j-1][l], QB - j);
        end
      end
      zf_q[0] <= zero4_q;
      for (int j = 1; j <= QB; j++) begin
        zf_q[j] <= zf_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [31:0] nd;
    logic signed [33:0] h;
    logic [31:0] res [3];
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        if (dv_q[QB][l].sat) begin
          nd = dv_q[QB][l].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          nd = dv_q[QB][l].neg ? -$signed({1'b0, dv_q[QB][l].q})
                               : $signed({1'b0, dv_q[QB][l].q});
        end
        h = (34'(nd) + (34'sd1 <<< F)) >>> 1;
        if (l == 1) begin
          h = (34'sd1 <<< F) - h;
        end
        res[l] = zf_q[QB] ? 32'd0 : h[31:0];
      end
      out_data_q <= {res[2], res[1], res[0]};
      out_user_q <= !zf_q[QB];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tuser_o = out_user_q;
endmodule
`default_nettype wire

/* rtl/vp_checker.sv */
// Port checker for the vertex projection block, bound to the top level.
// Depends on vp_pkg and vertex_project_top_assert.svh.
`default_nettype none
`include "vertex_project_top_assert.svh"
module vp_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid_i,
  input wire logic                      s_axis_tready_o,
  input wire logic [vp_pkg::IN_DW-1:0]  s_axis_tdata_i,
  input wire logic                      s_axis_tuser_i,
  input wire logic                      m_axis_tvalid_o,
  input wire logic                      m_axis_tready_i,
  input wire logic [vp_pkg::OUT_DW-1:0] m_axis_tdata_o,
  input wire logic                      m_axis_tuser_o
);
  logic unused_data;
  assign unused_data = ^s_axis_tdata_i;

  `VP_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `VP_ASSERT_NXT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  `VP_ASSERT_IMP(a_invalid_zero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0)
  `VP_ASSERT_IMP(a_load_idle, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == vp_pkg::FUNC_LOAD, !m_axis_tvalid_o)
endmodule

bind vertex_project_top vp_checker u_vp_checker (.*);
`default_nettype wire
